>>> design/alqm_pkg.sv
// shared types and constants for the audio level quality meter
`default_nettype none

package alqm_pkg;

  localparam int unsigned WindowLengthDef = 256;

  localparam int unsigned MagW    = 15;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RatioW  = 30;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;

  localparam int unsigned DivNumW = 30;
  localparam int unsigned DivDenW = 15;

  localparam logic [MagW-1:0] FullScale     = 15'd32767;
  localparam logic [MagW-1:0] NoiseReset    = 15'd32;
  localparam logic [MagW-1:0] OverloadReset = 15'd23200;
  localparam logic [MagW-1:0] DropoutReset  = 15'd100;

  localparam logic [CfgIdxW-1:0] RegOverload  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDropout   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSnrEnable = 2'd2;

  typedef struct packed {
    logic win_end;
    logic overload;
    logic clip;
    logic dropout;
  } stat_flags_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

  // value times full scale, as a shift and subtract
  function automatic logic [RatioW-1:0] times_full_scale(input logic [MagW-1:0] v);
    return {v, 15'd0} - {15'd0, v};
  endfunction

endpackage

`default_nettype wire

>>> design/audio_level_quality_meter.sv
// top level: config registers, window-end sequencer and result register
//
//  channel   direction  handshake                    payload
//  sample    in         in_valid_i / in_ready_o      sample_i
//  result    out        out_valid_o / out_ready_i    window_done_o .. dropout_total_o
//  config    in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// an item inside a window is accepted (statistics update), then its result is loaded
// a window-ending item steps through accept, mean square, crest start, crest divide,
//   noise floor, snr divide and result load
// zero mean square skips the crest divide, snr off or a zero floor skips the snr divide
// in_ready_o is high only in the idle state; a held result stalls the next load
// reset is asynchronous, active low; no clearing pass is needed
`default_nettype none

module audio_level_quality_meter import alqm_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = WindowLengthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     window_done_o,
  output logic                     overload_flag_o,
  output logic                     clip_flag_o,
  output logic                     dropout_flag_o,
  output logic [MagW-1:0]          peak_mag_o,
  output logic [MagW-1:0]          mean_square_o,
  output logic [RatioW-1:0]        crest_ratio_o,
  output logic [RatioW-1:0]        snr_ratio_o,
  output logic [MagW-1:0]          noise_level_o,
  output logic [CountW-1:0]        overload_total_o,
  output logic [CountW-1:0]        clip_total_o,
  output logic [CountW-1:0]        dropout_total_o
);

  localparam int unsigned PosW   = $clog2(WINDOW_LENGTH);
  localparam int unsigned SumW   = PosW + MagW;
  localparam int unsigned RecipW = SumW + 1;
  // rounded-up reciprocal of the window length, exact over the whole sum range
  localparam longint unsigned RecipFull =
    ((64'd1 << (SumW + PosW)) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EMIT  = 7'b0000010,
    S_MS    = 7'b0000100,
    S_CREST = 7'b0001000,
    S_NOISE = 7'b0010000,
    S_SNR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e            state_d, state_q;
  logic [MagW-1:0]   ovl_level_q, drp_level_q;
  logic              snr_en_q;
  logic [MagW-1:0]   ms_d, ms_q;
  logic [RatioW-1:0] crest_d, crest_q;
  logic [RatioW-1:0] snr_d, snr_q;
  logic [MagW-1:0]   nf_d, nf_q;
  logic [MagW-1:0]   nf_new;
  logic [SumW+RecipW-1:0] ms_prod;
  logic [MagW-1:0]   ms_calc;
  logic              accept;
  logic              out_free;
  logic              load;
  logic              out_valid_d, out_valid_q;

  stat_flags_t       flags;
  logic [MagW-1:0]   peak;
  logic [SumW-1:0]   sum;
  logic [CountW-1:0] ovl_total, clp_total, drp_total;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign ms_prod    = sum * Recip;
  assign ms_calc    = ms_prod[SumW+PosW +: MagW];

  alqm_stats #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_stats (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .sample_i         (sample_i),
    .overload_level_i (ovl_level_q),
    .dropout_level_i  (drp_level_q),
    .flags_o          (flags),
    .peak_o           (peak),
    .sum_o            (sum),
    .overload_total_o (ovl_total),
    .clip_total_o     (clp_total),
    .dropout_total_o  (drp_total)
  );

  alqm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_level_q <= OverloadReset;
      drp_level_q <= DropoutReset;
      snr_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOverload:  ovl_level_q <= cfg_wdata_i[MagW-1:0];
        RegDropout:   drp_level_q <= cfg_wdata_i[MagW-1:0];
        RegSnrEnable: snr_en_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    ms_d    = ms_q;
    crest_d = crest_q;
    snr_d   = snr_q;
    nf_d    = nf_q;
    load    = 1'b0;
    div_req = '0;
    nf_new  = (ms_q < nf_q) ? ms_q : nf_q + ((ms_q - nf_q) >> 4);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (flags.win_end) begin
          ms_d    = ms_calc;
          state_d = S_MS;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MS: begin
        if (ms_q != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = times_full_scale(peak);
          div_req.divisor  = ms_q;
          state_d          = S_CREST;
        end else begin
          state_d = S_NOISE;
        end
      end
      S_CREST: begin
        if (div_rsp.done) begin
          crest_d = div_rsp.quotient[RatioW-1:0];
          state_d = S_NOISE;
        end
      end
      S_NOISE: begin
        if (snr_en_q) begin
          nf_d = nf_new;
          if (nf_new != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = times_full_scale(ms_q);
            div_req.divisor  = nf_new;
            state_d          = S_SNR;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_SNR: begin
        if (div_rsp.done) begin
          snr_d   = div_rsp.quotient[RatioW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ms_q        <= '0;
      crest_q     <= '0;
      snr_q       <= '0;
      nf_q        <= NoiseReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ms_q        <= ms_d;
      crest_q     <= crest_d;
      snr_q       <= snr_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      window_done_o    <= flags.win_end;
      overload_flag_o  <= flags.overload;
      clip_flag_o      <= flags.clip;
      dropout_flag_o   <= flags.dropout;
      peak_mag_o       <= peak;
      mean_square_o    <= ms_q;
      crest_ratio_o    <= crest_q;
      snr_ratio_o      <= snr_q;
      noise_level_o    <= nf_q;
      overload_total_o <= ovl_total;
      clip_total_o     <= clp_total;
      dropout_total_o  <= drp_total;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_CREST || state_q == S_SNR))
    else $error("divider result outside a wait state");

  a_accept_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EMIT))
    else $error("accepted item not followed by emit");

  a_window_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && flags.win_end) |=> (state_q == S_MS && !div_rsp.busy))
    else $error("window end did not reach the mean square step");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire

>>> design/alqm_stats.sv
// per-item statistics: magnitude, flags, saturating counters, window peak and sum
`default_nettype none

module alqm_stats import alqm_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = WindowLengthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [SampleW-1:0]    sample_i,
  input  wire logic [MagW-1:0]       overload_level_i,
  input  wire logic [MagW-1:0]       dropout_level_i,
  output stat_flags_t                flags_o,
  output logic [MagW-1:0]            peak_o,
  output logic [$clog2(WINDOW_LENGTH)+MagW-1:0] sum_o,
  output logic [CountW-1:0]          overload_total_o,
  output logic [CountW-1:0]          clip_total_o,
  output logic [CountW-1:0]          dropout_total_o
);

  localparam int unsigned PosW = $clog2(WINDOW_LENGTH);
  localparam int unsigned SumW = PosW + MagW;
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_LENGTH - 1);

  logic [SampleW-1:0] neg_w;
  logic [MagW-1:0]    mag;
  logic [2*MagW-1:0]  prod;
  logic [MagW-1:0]    sq;
  logic [MagW-1:0]    peak_base;
  logic [SumW-1:0]    sum_base;
  stat_flags_t        flags_d, flags_q;
  logic [MagW-1:0]    peak_d, peak_q;
  logic [SumW-1:0]    sum_d, sum_q;
  logic [PosW-1:0]    pos_d, pos_q;
  logic               restart_d, restart_q;
  logic [CountW-1:0]  ovl_cnt_d, ovl_cnt_q;
  logic [CountW-1:0]  clp_cnt_d, clp_cnt_q;
  logic [CountW-1:0]  drp_cnt_d, drp_cnt_q;

  always_comb begin
    neg_w = (~sample_i) + 16'd1;
    if (!sample_i[SampleW-1]) begin
      mag = sample_i[MagW-1:0];
    end else if (neg_w[SampleW-1]) begin
      mag = FullScale;
    end else begin
      mag = neg_w[MagW-1:0];
    end
    prod = mag * mag;
    sq   = prod[2*MagW-1:MagW];

    peak_base = restart_q ? '0 : peak_q;
    sum_base  = restart_q ? '0 : sum_q;

    flags_d.overload = (mag > overload_level_i);
    flags_d.clip     = (mag >= FullScale);
    flags_d.dropout  = (mag < dropout_level_i);
    flags_d.win_end  = (pos_q == LastPos);

    peak_d    = (mag > peak_base) ? mag : peak_base;
    sum_d     = sum_base + SumW'(sq);
    pos_d     = flags_d.win_end ? '0 : pos_q + 1'b1;
    restart_d = flags_d.win_end;

    ovl_cnt_d = ovl_cnt_q + CountW'(flags_d.overload && (ovl_cnt_q != '1));
    clp_cnt_d = clp_cnt_q + CountW'(flags_d.clip && (clp_cnt_q != '1));
    drp_cnt_d = drp_cnt_q + CountW'(flags_d.dropout && (drp_cnt_q != '1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      peak_q    <= '0;
      sum_q     <= '0;
      pos_q     <= '0;
      restart_q <= 1'b0;
      ovl_cnt_q <= '0;
      clp_cnt_q <= '0;
      drp_cnt_q <= '0;
    end else if (step_i) begin
      flags_q   <= flags_d;
      peak_q    <= peak_d;
      sum_q     <= sum_d;
      pos_q     <= pos_d;
      restart_q <= restart_d;
      ovl_cnt_q <= ovl_cnt_d;
      clp_cnt_q <= clp_cnt_d;
      drp_cnt_q <= drp_cnt_d;
    end
  end

  assign flags_o          = flags_q;
  assign peak_o           = peak_q;
  assign sum_o            = sum_q;
  assign overload_total_o = ovl_cnt_q;
  assign clip_total_o     = clp_cnt_q;
  assign dropout_total_o  = drp_cnt_q;

  a_pos_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pos_q == LastPos) |=> (pos_q == '0 && restart_q))
    else $error("window position did not wrap at window end");

  a_peak_covers_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && flags_d.clip) |=> (peak_q == FullScale))
    else $error("clipped item not reflected in window peak");

  a_sat_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovl_cnt_q == '1) |=> (ovl_cnt_q == '1))
    else $error("overload counter left saturation");

endmodule

`default_nettype wire

>>> design/alqm_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module alqm_div import alqm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  div_req_t  req_i,
  output div_rsp_t  rsp_o
);

  localparam int unsigned CntW = $clog2(DivNumW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(DivNumW);

  logic               busy_d, busy_q;
  logic               done_d, done_q;
  logic [CntW-1:0]    cnt_d, cnt_q;
  logic [DivNumW-1:0] num_d, num_q;
  logic [DivDenW:0]   rem_d, rem_q;
  logic [DivDenW-1:0] den_d, den_q;
  logic [DivDenW:0]   rem_shift;
  logic [DivDenW+1:0] diff;

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    num_d     = num_q;
    rem_d     = rem_q;
    den_d     = den_q;
    rem_shift = {rem_q[DivDenW-1:0], num_q[DivNumW-1]};
    diff      = {1'b0, rem_shift} - {2'b00, den_q};
    if (busy_q) begin
      if (diff[DivDenW+1]) begin
        rem_d = rem_shift;
        num_d = {num_q[DivNumW-2:0], 1'b0};
      end else begin
        rem_d = diff[DivDenW:0];
        num_d = {num_q[DivNumW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = Steps;
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divide started while busy");

  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (req_i.divisor != '0))
    else $error("divide by zero requested");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divide done without running");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// testbench for audio_level_quality_meter: directed and random samples checked against a predictor
`default_nettype none

module tb_top import alqm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinLen      = WindowLengthDef;
  localparam int unsigned StallCycles = 400;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned MaxReports  = 40;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam int DirectedSamples [22] = '{
    0, 1, -1, 32767, -32767, -32768, 16384, -16384, 23200, 23201, -23201,
    99, 100, -99, -100, 101, 181, 182, -182, 32766, 21845, -21846
  };

  typedef enum int {ProfFull, ProfQuiet, ProfLoud, ProfEdge, ProfLow} profile_e;

  localparam profile_e ProfileOrder [6] = '{
    ProfFull, ProfQuiet, ProfLoud, ProfQuiet, ProfEdge, ProfLow
  };

  typedef struct packed {
    logic              win_done;
    logic              ovl;
    logic              clp;
    logic              drp;
    logic [MagW-1:0]   peak;
    logic [MagW-1:0]   ms;
    logic [RatioW-1:0] crest;
    logic [RatioW-1:0] snr;
    logic [MagW-1:0]   noise;
    logic [CountW-1:0] ovl_cnt;
    logic [CountW-1:0] clp_cnt;
    logic [CountW-1:0] drp_cnt;
  } meter_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgW-1:0]      cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SampleW-1:0]   in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 sample_taken = 1'b0;
  meter_result_t        dut_result;

  // meter state mirrored by the predictor
  logic [MagW-1:0]      ovl_level_q = OverloadReset;
  logic [MagW-1:0]      drop_level_q = DropoutReset;
  logic                 snr_en_q = 1'b1;
  int unsigned          sq_sum = 0;
  int unsigned          win_pos = 0;
  logic [MagW-1:0]      win_peak = '0;
  logic [MagW-1:0]      ms_last = '0;
  logic [RatioW-1:0]    crest_last = '0;
  logic [RatioW-1:0]    snr_last = '0;
  logic [MagW-1:0]      noise_floor = NoiseReset;
  logic [CountW-1:0]    ovl_cnt = '0;
  logic [CountW-1:0]    clp_cnt = '0;
  logic [CountW-1:0]    drp_cnt = '0;

  logic [SampleW-1:0]   pending_samples [$];
  meter_result_t        expected_results [$];

  int unsigned          sender_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          stall_requests = 0;
  int unsigned          stall_served = 0;
  int unsigned          stall_left = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          gen_pos = 0;
  int unsigned          windows_planned = 0;
  profile_e             window_profile = ProfFull;
  int unsigned          samples_accepted = 0;
  int unsigned          windows_closed = 0;
  int unsigned          config_writes = 0;
  int unsigned          errors = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  audio_level_quality_meter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_i        (in_sample),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .window_done_o   (dut_result.win_done),
    .overload_flag_o (dut_result.ovl),
    .clip_flag_o     (dut_result.clp),
    .dropout_flag_o  (dut_result.drp),
    .peak_mag_o      (dut_result.peak),
    .mean_square_o   (dut_result.ms),
    .crest_ratio_o   (dut_result.crest),
    .snr_ratio_o     (dut_result.snr),
    .noise_level_o   (dut_result.noise),
    .overload_total_o(dut_result.ovl_cnt),
    .clip_total_o    (dut_result.clp_cnt),
    .dropout_total_o (dut_result.drp_cnt)
  );

  function automatic meter_result_t level_meter_step(input logic [SampleW-1:0] s);
    int unsigned     mag;
    int unsigned     ms;
    longint unsigned prod;
    meter_result_t   r;
    if (s[SampleW-1]) begin
      mag = 32'h10000 - s;
      if (mag > FullScale) mag = FullScale;
    end else begin
      mag = 32'(s);
    end
    if (mag > win_peak) win_peak = MagW'(mag);
    r = '0;
    r.ovl = mag > ovl_level_q;
    r.clp = mag >= FullScale;
    r.drp = mag < drop_level_q;
    if (r.ovl && ovl_cnt != '1) ovl_cnt = ovl_cnt + 1;
    if (r.clp && clp_cnt != '1) clp_cnt = clp_cnt + 1;
    if (r.drp && drp_cnt != '1) drp_cnt = drp_cnt + 1;
    sq_sum = sq_sum + ((mag * mag) >> 15);
    win_pos = win_pos + 1;
    r.peak = win_peak;
    if (win_pos >= WinLen) begin
      ms = sq_sum / WinLen;
      if (ms > FullScale) ms = FullScale;
      ms_last = MagW'(ms);
      if (ms > 0) begin
        prod = 64'(win_peak);
        prod = prod * FullScale;
        crest_last = RatioW'(prod / ms);
      end
      if (snr_en_q) begin
        // floor drops at once, climbs by a sixteenth of the gap
        if (ms < noise_floor) begin
          noise_floor = MagW'(ms);
        end else begin
          noise_floor = MagW'(noise_floor + ((ms - noise_floor) >> 4));
        end
        if (noise_floor != 0) begin
          prod = 64'(ms);
          prod = prod * FullScale;
          snr_last = RatioW'(prod / noise_floor);
        end
      end
      r.win_done = 1'b1;
      win_pos = 0;
      sq_sum = 0;
      win_peak = '0;
    end
    r.ms = ms_last;
    r.crest = crest_last;
    r.snr = snr_last;
    r.noise = noise_floor;
    r.ovl_cnt = ovl_cnt;
    r.clp_cnt = clp_cnt;
    r.drp_cnt = drp_cnt;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] random_sample(input profile_e p);
    int v;
    case (p)
      ProfQuiet: begin
        v = int'($urandom_range(0, 362)) - 181;
      end
      ProfLoud: begin
        v = int'($urandom_range(0, 4096)) + 28672;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      ProfEdge: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = int'(ovl_level_q) + int'($urandom_range(0, 2)) - 1;
          default: v = int'(drop_level_q) + int'($urandom_range(0, 2)) - 1;
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      ProfLow: begin
        v = int'($urandom_range(0, 4000)) - 2000;
      end
      default: begin
        v = int'($urandom_range(0, 65535));
      end
    endcase
    return SampleW'(v);
  endfunction

  task automatic queue_random_samples(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (gen_pos == 0) begin
        if (windows_planned < 6) begin
          window_profile = ProfileOrder[windows_planned];
        end else begin
          window_profile = profile_e'($urandom_range(0, 4));
        end
        windows_planned++;
      end
      pending_samples.push_back(random_sample(window_profile));
      gen_pos = (gen_pos + 1) % WinLen;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      RegOverload:  ovl_level_q = data;
      RegDropout:   drop_level_q = data;
      RegSnrEnable: snr_en_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    config_writes++;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // sample driver
  always @(negedge clk_i) begin
    if (rst_n && (!in_valid || sample_taken)) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expected_results.push_back(level_meter_step(in_sample));
      samples_accepted++;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left <= StallCycles;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    meter_result_t want;
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result with no sample pending, expected none, actual peak %0d",
                   $time, dut_result.peak);
        end
      end else begin
        want = expected_results.pop_front();
        check_field("window_done", want.win_done, dut_result.win_done);
        check_field("overload_flag", want.ovl, dut_result.ovl);
        check_field("clip_flag", want.clp, dut_result.clp);
        check_field("dropout_flag", want.drp, dut_result.drp);
        check_field("peak_mag", want.peak, dut_result.peak);
        check_field("mean_square", want.ms, dut_result.ms);
        check_field("crest_ratio", want.crest, dut_result.crest);
        check_field("snr_ratio", want.snr, dut_result.snr);
        check_field("noise_level", want.noise, dut_result.noise);
        check_field("overload_total", want.ovl_cnt, dut_result.ovl_cnt);
        check_field("clip_total", want.clp_cnt, dut_result.clp_cnt);
        check_field("dropout_total", want.drp_cnt, dut_result.drp_cnt);
        if (want.win_done) windows_closed++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset thresholds, then the edges around them
    sender_idle_pct = 34;
    recv_idle_pct = 53;
    foreach (DirectedSamples[k]) pending_samples.push_back(SampleW'(DirectedSamples[k]));
    gen_pos = $size(DirectedSamples);
    windows_planned = 1;
    wait_idle();

    // every nonzero sample overloads, nearly everything drops out
    write_reg(RegOverload, '0);
    write_reg(RegDropout, 15'h7FFF);
    write_reg(RegSnrEnable, 15'h7FFF);
    write_reg(RegUnused, CfgW'($urandom));
    @(posedge clk_i);
    queue_random_samples(610);
    wait_idle();

    // nothing overloads or drops out, noise floor frozen
    sender_idle_pct = 53;
    recv_idle_pct = 34;
    write_reg(RegOverload, 15'h7FFF);
    write_reg(RegDropout, '0);
    write_reg(RegSnrEnable, 15'h7FFE);
    @(posedge clk_i);
    queue_random_samples(610);
    wait_idle();

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegOverload, CfgW'($urandom_range(16000, 30000)));
    write_reg(RegDropout, CfgW'($urandom_range(50, 3000)));
    write_reg(RegSnrEnable, 15'h0001);
    @(negedge clk_i);
    stall_requests <= stall_requests + 1;
    @(posedge clk_i);
    queue_random_samples(620);
    wait_idle();

    $display("tb_top: %0d samples checked over %0d closed windows, %0d register writes",
             samples_accepted, windows_closed, config_writes);
    $display("tb_top: quiet, loud and threshold windows under three handshake mixes");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/alqm_pkg.sv
design/alqm_stats.sv
design/alqm_div.sv
design/audio_level_quality_meter.sv
dv/tb_top.sv
